[hw/rtl/utf8_to_cp437_transcoder_unit_macros.svh]
// assertion helpers for the transcoder
`ifndef UTF8_TO_CP437_TRANSCODER_UNIT_MACROS_SVH
`define UTF8_TO_CP437_TRANSCODER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define U2C_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define U2C_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/u2c_pkg.sv]
package u2c_pkg;

  localparam int CP_W            = 32;
  localparam int BYTE_W          = 8;
  localparam int GLYPH_COUNT     = 80;
  localparam int CMD_QUEUE_DEPTH = 4;

  localparam logic [BYTE_W-1:0] UNKNOWN_CHAR = 8'h3F;
  localparam logic [BYTE_W-1:0] TERMINATOR   = 8'h00;

  // glyph bytes: 1..31 for the first run, then DEL, then the box-drawing run
  localparam int LOW_RUN_LEN  = 31;
  localparam int DEL_INDEX    = 31;
  localparam int BOX_START    = 32;
  localparam logic [BYTE_W-1:0] DEL_GLYPH = 8'd127;
  localparam int BOX_BASE     = 176;

  localparam logic [15:0] GLYPH_CP [GLYPH_COUNT] = '{
    16'h263A, 16'h263B, 16'h2665, 16'h2666, 16'h2663, 16'h2660, 16'h2022, 16'h25D8,
    16'h25CB, 16'h25D9, 16'h2642, 16'h2640, 16'h266A, 16'h266B, 16'h263C, 16'h25BA,
    16'h25C4, 16'h2195, 16'h203C, 16'h00B6, 16'h00A7, 16'h25AC, 16'h21A8, 16'h2191,
    16'h2193, 16'h2192, 16'h2190, 16'h221F, 16'h2194, 16'h25B2, 16'h25BC, 16'h2302,
    16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
    16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
    16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
    16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
    16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
    16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580
  };

  // one accepted byte turns into up to three output slots, in this order
  typedef struct packed {
    logic              flush_v;
    logic [CP_W-1:0]   flush_cp;
    logic              lit_v;
    logic [BYTE_W-1:0] lit_byte;
    logic              term_v;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic head_v;
  } q_status_t;

  function automatic logic [BYTE_W-1:0] glyph_byte(input int idx);
    logic [BYTE_W-1:0] res;
    if (idx < LOW_RUN_LEN) begin
      res = BYTE_W'(idx + 1);
    end else if (idx == DEL_INDEX) begin
      res = DEL_GLYPH;
    end else begin
      res = BYTE_W'(idx - BOX_START + BOX_BASE);
    end
    return res;
  endfunction

  function automatic logic [BYTE_W-1:0] map_glyph(input logic [CP_W-1:0] cp);
    logic [BYTE_W-1:0] res;
    res = UNKNOWN_CHAR;
    for (int i = 0; i < GLYPH_COUNT; i++) begin
      if (cp == {16'h0000, GLYPH_CP[i]}) begin
        res = glyph_byte(i);
      end
    end
    return res;
  endfunction

endpackage

[hw/rtl/u2c_front.sv]
module u2c_front
  import u2c_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_end_of_string,
  output logic              q_push,
  output cmd_t              cmd,
  output logic              pend_zero
);

  logic [CP_W-1:0] pending_r, pending_nxt;
  logic            is_ascii, is_cont;
  logic [CP_W-1:0] shifted;
  logic [4:0]      payload;
  logic            pend_nz;

  assign is_ascii = ~in_byte[7];
  assign is_cont  = in_byte[7:6] == 2'b10;
  assign shifted  = {pending_r[CP_W-7:0], in_byte[5:0]};
  assign pend_nz  = pending_r != '0;

  always_comb begin
    if (in_byte[7:5] == 3'b110) begin
      payload = in_byte[4:0];
    end else if (in_byte[7:4] == 4'b1110) begin
      payload = {1'b0, in_byte[3:0]};
    end else if (in_byte[7:3] == 5'b11110) begin
      payload = {2'b00, in_byte[2:0]};
    end else begin
      payload = '0;
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.term_v   = in_end_of_string;
    cmd.lit_byte = in_byte;
    if (is_ascii) begin
      cmd.flush_v  = pend_nz;
      cmd.flush_cp = pending_r;
      cmd.lit_v    = 1'b1;
      pending_nxt  = '0;
    end else if (is_cont) begin
      cmd.flush_v  = in_end_of_string && (shifted != '0);
      cmd.flush_cp = shifted;
      pending_nxt  = in_end_of_string ? '0 : shifted;
    end else begin
      cmd.flush_v  = pend_nz;
      cmd.flush_cp = pending_r;
      // a bare payload is below every table entry, so it always maps to unknown
      cmd.lit_v    = in_end_of_string && (payload != '0);
      cmd.lit_byte = UNKNOWN_CHAR;
      pending_nxt  = in_end_of_string ? '0 : CP_W'(payload);
    end
  end

  assign q_push    = accept && (cmd.flush_v || cmd.lit_v || cmd.term_v);
  assign pend_zero = !pend_nz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (accept) begin
      pending_r <= pending_nxt;
    end
  end

endmodule

[hw/rtl/u2c_cmd_queue.sv]
module u2c_cmd_queue
  import u2c_pkg::*;
#(
  parameter int DEPTH = CMD_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_push,
  input  cmd_t      push_cmd,
  input  logic      q_pop,
  output cmd_t      head_cmd,
  output q_status_t status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] ptr);
    return (ptr == PW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  always_comb begin
    case ({q_push, q_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  assign head_cmd      = mem_r[rd_ptr_r];
  assign status.full   = count_r == CW'(DEPTH);
  assign status.head_v = count_r != '0;

  always_ff @(posedge clk) begin
    if (q_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (q_push) begin
        wr_ptr_r <= wrap_inc(wr_ptr_r);
      end
      if (q_pop) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
      count_r <= count_nxt;
    end
  end

endmodule

[hw/rtl/u2c_back.sv]
module u2c_back
  import u2c_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              head_cmd,
  input  logic              head_v,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last_of_run
);

  // slot order: bit 0 flush, bit 1 literal, bit 2 terminator
  logic [2:0]        done_r, done_nxt;
  logic [2:0]        rem, pick, rem_after;
  logic              step, last_slot;
  logic [BYTE_W-1:0] slot_byte;
  logic              out_v_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;

  assign rem       = {head_cmd.term_v, head_cmd.lit_v, head_cmd.flush_v} & ~done_r;
  assign pick      = rem & (~rem + 1'b1);
  assign rem_after = rem & ~pick;
  assign last_slot = rem_after == '0;
  assign step      = head_v && (!out_v_r || pop);
  assign q_pop     = step && last_slot;

  always_comb begin
    if (pick[0]) begin
      slot_byte = map_glyph(head_cmd.flush_cp);
    end else if (pick[1]) begin
      slot_byte = head_cmd.lit_byte;
    end else begin
      slot_byte = TERMINATOR;
    end
  end

  always_comb begin
    done_nxt = done_r;
    if (step) begin
      done_nxt = last_slot ? '0 : (done_r | pick);
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte_r <= slot_byte;
      out_last_r <= last_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
      if (step) begin
        out_v_r <= 1'b1;
      end else if (pop) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign empty           = !out_v_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;

endmodule

[hw/rtl/utf8_to_cp437_transcoder_unit.sv]
// UTF-8 to code page 437 transcoder. Bytes of a UTF-8 string go in one per transfer on the
// input queue port (push/full); single-byte CP437 characters come out on the result queue port
// (empty/pop), each with out_last_of_run set on the final result that its input byte caused.
// Lead, ASCII and end-of-string bytes flush the pending code point through the glyph table
// (unknown code points become '?'); end of string adds a 0 terminator. A byte can cause zero to
// three results. The front accepts one byte every cycle while the command queue has room; the
// back drains one result per cycle through the output register while that register is empty or
// being popped, and QUEUE_DEPTH commands absorb the bursts. The earliest result reaches the
// result ports through the command queue and then the output register: the command enters the
// queue at its byte's transfer and the table lookup lands in the output register after that.
`include "utf8_to_cp437_transcoder_unit_macros.svh"

module utf8_to_cp437_transcoder_unit
  import u2c_pkg::*;
#(
  parameter int QUEUE_DEPTH = CMD_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  // input queue side
  input  logic              push,
  output logic              full,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_end_of_string,
  // result queue side
  output logic              empty,
  input  logic              pop,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last_of_run
);

  logic      accept;
  logic      q_push, q_pop;
  cmd_t      push_cmd, head_cmd;
  q_status_t q_stat;
  logic      pend_zero;

  // a byte is taken whenever the command queue has room
  assign full   = q_stat.full;
  assign accept = push && !full;

  // front: classify the byte, update the pending code point, build the slot command
  u2c_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (accept),
    .in_byte          (in_byte),
    .in_end_of_string (in_end_of_string),
    .q_push           (q_push),
    .cmd              (push_cmd),
    .pend_zero        (pend_zero)
  );

  // short queue of commands between front and back
  u2c_cmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_push   (q_push),
    .push_cmd (push_cmd),
    .q_pop    (q_pop),
    .head_cmd (head_cmd),
    .status   (q_stat)
  );

  // back: walk the slots of the head command, look up glyphs, register results
  u2c_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_cmd        (head_cmd),
    .head_v          (q_stat.head_v),
    .q_pop           (q_pop),
    .empty           (empty),
    .pop             (pop),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

  // the queue never takes a command while full
  `U2C_ASSERT_IMP(a_no_push_full, clk, rst_n, q_push, !q_stat.full, "push into full queue")
  // the back only retires a command that is there
  `U2C_ASSERT_IMP(a_pop_valid, clk, rst_n, q_pop, q_stat.head_v, "pop of empty queue")
  // end of string always leaves nothing pending
  `U2C_ASSERT_NXT(a_eos_clears, clk, rst_n, accept && in_end_of_string, pend_zero,
                  "pending code point left after end of string")

endmodule
